// File: hdl/gkd_pkg.sv
// ----------------------------------------------------------------------------
// gkd_pkg: shared types and constants of the Gaussian kernel density core
// Payload structs, fixed-point constants of the exp evaluation, and queue
// sizes.
// ----------------------------------------------------------------------------
package gkd_pkg;

    // One input transaction: a signed Q4.12 component and its last flag
    typedef struct packed {
        logic signed [15:0] component;
        logic               last;
    } t_in;

    // One result transaction: unsigned Q16.16 density and saturation flag
    typedef struct packed {
        logic [31:0] density;
        logic        saturated;
    } t_out;

    // One finished vector handed from front to back
    typedef struct packed {
        logic [31:0] sum;
        logic        ovf;
    } t_job;

    // Q0.32 constants
    localparam logic [31:0] LOG2E_HALF = 32'd3098164009;   // 0.5*log2(e)
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;   // ln(2)
    localparam logic [31:0] NORM_RESET = 32'd26145;

    // Taylor series of exp(-u)
    localparam int SERIES_TERMS = 12;
    localparam int K_W          = 4;        // holds term index up to SERIES_TERMS
    localparam int TERM_W       = 32;
    localparam int DIV_DIGIT    = 4;        // quotient bits per divider cycle
    localparam int DIV_STEPS    = TERM_W / DIV_DIGIT;

    // Queue depths
    localparam int JOB_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    // Configuration port
    localparam int ADDR_W = 3;

endpackage

// File: hdl/gkd_fifo.sv
// ----------------------------------------------------------------------------
// gkd_fifo: small synchronous queue
// Register-based FIFO with first-word-fall-through read side.
// ----------------------------------------------------------------------------
module gkd_fifo #(
    parameter int WIDTH = $bits(gkd_pkg::t_job),
    parameter int DEPTH = gkd_pkg::JOB_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hdl/gkd_front.sv
// ----------------------------------------------------------------------------
// gkd_front: sum-of-squares accumulator
// Squares each component and adds it into a saturating Q8.24 sum; the item
// flagged last hands the finished sum to the job queue and clears it.
// ----------------------------------------------------------------------------
module gkd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gkd_pkg::t_in   i_item,
    input  logic           i_job_full,
    output logic           o_job_push,
    output gkd_pkg::t_job  o_job
);
    import gkd_pkg::*;

    logic [31:0] r_sum, n_sum;
    logic        r_ovf, n_ovf;
    logic        accept;
    logic [15:0] mag;
    logic [31:0] sq;
    logic [32:0] sum_wide;
    logic [31:0] sum_sat;
    logic        sum_clip;

    assign accept = i_push && !i_job_full;

    // magnitude and square; the most negative code maps to 0x8000
    assign mag = i_item.component[15] ? (16'd0 - i_item.component) : i_item.component;
    assign sq  = {16'd0, mag} * {16'd0, mag};

    // saturating add
    assign sum_wide = {1'b0, r_sum} + {1'b0, sq};
    assign sum_clip = sum_wide[32];
    assign sum_sat  = sum_clip ? '1 : sum_wide[31:0];

    assign o_job_push = accept && i_item.last;
    assign o_job.sum  = sum_sat;
    assign o_job.ovf  = r_ovf || sum_clip;

    always_comb begin
        n_sum = r_sum;
        n_ovf = r_ovf;
        if (accept) begin
            if (i_item.last) begin
                n_sum = '0;
                n_ovf = 1'b0;
            end else begin
                n_sum = sum_sat;
                n_ovf = r_ovf || sum_clip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_sum <= n_sum;
            r_ovf <= n_ovf;
        end
    end

endmodule

// File: hdl/gkd_div.sv
// ----------------------------------------------------------------------------
// gkd_div: small-divisor iterative divider
// Restoring division of a 32-bit term by a 4-bit index, several quotient
// bits per cycle.
// ----------------------------------------------------------------------------
module gkd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [gkd_pkg::TERM_W-1:0] i_dividend,
    input  logic [gkd_pkg::K_W-1:0]    i_divisor,
    output logic                       o_done,
    output logic [gkd_pkg::TERM_W-1:0] o_quot
);
    import gkd_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [TERM_W-1:0] r_q;
    logic [K_W-1:0]    r_rem;
    logic [K_W-1:0]    r_div;
    logic [TERM_W-1:0] step_q;
    logic [K_W-1:0]    step_rem;

    // one group of quotient bits, MSB first
    always_comb begin
        logic [K_W:0] trial;
        step_q   = r_q;
        step_rem = r_rem;
        for (int i = 0; i < DIV_DIGIT; i++) begin
            trial  = {step_rem, step_q[TERM_W-1]};
            step_q = {step_q[TERM_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                trial     = trial - {1'b0, r_div};
                step_q[0] = 1'b1;
            end
            step_rem = trial[K_W-1:0];
        end
    end

    // control
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= step_q;
            r_rem <= step_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: hdl/gkd_back.sv
// ----------------------------------------------------------------------------
// gkd_back: exponential and scaling sequencer
// Turns one finished sum into norm_constant * exp(-sum/2) through a shared
// 32x32 multiplier, the series divider and a final rounding shift.
// ----------------------------------------------------------------------------
module gkd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_empty,
    input  gkd_pkg::t_job  i_job,
    output logic           o_job_pop,
    input  logic [31:0]    i_norm,
    input  logic           i_res_full,
    output logic           o_res_push,
    output gkd_pkg::t_out  o_res
);
    import gkd_pkg::*;

    localparam int ACC_W = 35;
    localparam logic [ACC_W-1:0] ACC_ONE = 35'h1_0000_0000;
    localparam logic [K_W-1:0]   K_FIRST = K_W'(2);
    localparam logic [K_W-1:0]   K_LAST  = K_W'(SERIES_TERMS);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_MT   = 11'b000_0000_0010,  // t = sum * log2(e)/2
        S_MF   = 11'b000_0000_0100,  // u = frac(t) * ln2
        S_U    = 11'b000_0000_1000,  // first series term
        S_TM   = 11'b000_0001_0000,  // term * u
        S_TS   = 11'b000_0010_0000,  // start divide by k
        S_TW   = 11'b000_0100_0000,  // wait quotient, accumulate
        S_P    = 11'b000_1000_0000,  // clamp series value
        S_MP   = 11'b001_0000_0000,  // norm * p
        S_SH   = 11'b010_0000_0000,  // scale by 2^-(32+n), round
        S_OUT  = 11'b100_0000_0000   // hand result to output queue
    } t_state;

    t_state            r_state, n_state;
    logic [K_W-1:0]    r_k, n_k;
    logic [31:0]       r_sum, n_sum;
    logic              r_ovf, n_ovf;
    logic [7:0]        r_n, n_n;
    logic [31:0]       r_u, n_u;
    logic [31:0]       r_term, n_term;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [32:0]       r_p, n_p;
    logic [32:0]       r_dens, n_dens;
    logic [63:0]       r_prod, n_prod;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;
    logic [63:0]       shifted;
    logic              div_start, div_done;
    logic [TERM_W-1:0] div_quot;

    gkd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod[63:32]),
        .i_divisor  (r_k),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // shared multiplier operand select
    always_comb begin
        mul_a = r_term;
        mul_b = r_u;
        case (r_state)
            S_MT: begin
                mul_a = r_sum;
                mul_b = LOG2E_HALF;
            end
            S_MF: begin
                mul_a = r_prod[55:24];
                mul_b = LN2_Q32;
            end
            S_MP: begin
                mul_a = i_norm;
                mul_b = r_p[31:0];
            end
            default: begin
                mul_a = r_term;
                mul_b = r_u;
            end
        endcase
    end

    assign mul_p     = {32'd0, mul_a} * {32'd0, mul_b};
    assign shifted   = r_prod >> r_n[4:0];
    assign div_start = (r_state == S_TS);
    assign o_job_pop = (r_state == S_IDLE) && !i_job_empty;

    // result formatting with output clamp
    assign o_res_push      = (r_state == S_OUT) && !i_res_full;
    assign o_res.density   = r_dens[32] ? '1 : r_dens[31:0];
    assign o_res.saturated = r_ovf || r_dens[32];

    // sequencer
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_sum   = r_sum;
        n_ovf   = r_ovf;
        n_n     = r_n;
        n_u     = r_u;
        n_term  = r_term;
        n_acc   = r_acc;
        n_p     = r_p;
        n_dens  = r_dens;
        n_prod  = r_prod;
        case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    n_sum   = i_job.sum;
                    n_ovf   = i_job.ovf;
                    n_state = S_MT;
                end
            end
            S_MT: begin
                n_prod  = mul_p;
                n_state = S_MF;
            end
            S_MF: begin
                n_n     = r_prod[63:56];
                n_prod  = mul_p;
                n_state = S_U;
            end
            S_U: begin
                // first term is u itself
                n_u     = r_prod[63:32];
                n_term  = r_prod[63:32];
                n_acc   = ACC_ONE - {3'd0, r_prod[63:32]};
                n_k     = K_FIRST;
                n_state = S_TM;
            end
            S_TM: begin
                n_prod  = mul_p;
                n_state = S_TS;
            end
            S_TS: begin
                n_state = S_TW;
            end
            S_TW: begin
                if (div_done) begin
                    n_term = div_quot;
                    if (r_k[0]) begin
                        n_acc = r_acc - {3'd0, div_quot};
                    end else begin
                        n_acc = r_acc + {3'd0, div_quot};
                    end
                    if (r_k == K_LAST) begin
                        n_state = S_P;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_TM;
                    end
                end
            end
            S_P: begin
                if (r_acc[ACC_W-1]) begin
                    n_p = '0;
                end else if (r_acc[ACC_W-2:0] > ACC_ONE[ACC_W-2:0]) begin
                    n_p = ACC_ONE[32:0];
                end else begin
                    n_p = r_acc[32:0];
                end
                n_state = S_MP;
            end
            S_MP: begin
                // p of exactly one scales by a plain shift
                n_prod  = r_p[32] ? {i_norm, 32'd0} : mul_p;
                n_state = S_SH;
            end
            S_SH: begin
                if (r_n < 8'd32) begin
                    n_dens = {1'b0, shifted[63:32]} + {32'd0, shifted[31]};
                end else if (r_n == 8'd32) begin
                    n_dens = {32'd0, r_prod[63]};
                end else begin
                    n_dens = '0;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= K_FIRST;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_ovf  <= n_ovf;
        r_n    <= n_n;
        r_u    <= n_u;
        r_term <= n_term;
        r_acc  <= n_acc;
        r_p    <= n_p;
        r_dens <= n_dens;
        r_prod <= n_prod;
    end

    // series index stays within the term range while the series runs
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TM || r_state == S_TS || r_state == S_TW) |->
        (r_k >= K_FIRST && r_k <= K_LAST))
        else $error("series index out of range");

    // a quotient only arrives while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_TW))
        else $error("divider finished outside wait state");

    // divider start is always followed by a wait state
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_state == S_TW))
        else $error("divider started without waiting");

    // a result leaves only from the output state into idle
    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |=> (r_state == S_IDLE))
        else $error("result push did not return to idle");

endmodule

// File: hdl/gaussian_kernel_density_core.sv
// ----------------------------------------------------------------------------
// gaussian_kernel_density_core: standard Gaussian kernel density evaluator
// Accumulates squared components of a vector and emits
// norm_constant * exp(-0.5 * sum) per vector.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  item      in         push / full            component (Q4.12), last
//  result    out        pop / empty            density (Q16.16), saturated
//  config    in         APB psel/penable       norm_constant at byte 0x0
//
//  A component is taken every cycle while the job queue has room.
//  In the back sequencer each vector's density runs eleven series terms,
//  each made of a multiply, a divider start, eight divide steps and the
//  quotient hand-back.
//  Two finished vectors may wait in the job queue; two results in the output
//  queue. A full output queue stalls the sequencer, then the job queue.
//  Reset is synchronous and active low; there is no clearing pass.
//
module gaussian_kernel_density_core #(
    parameter int JOB_DEPTH = gkd_pkg::JOB_DEPTH,
    parameter int RES_DEPTH = gkd_pkg::RES_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // item queue side
    input  logic                       push,
    input  gkd_pkg::t_in               i_item,
    output logic                       full,
    // result queue side
    output logic                       empty,
    input  logic                       pop,
    output gkd_pkg::t_out              o_result,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gkd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import gkd_pkg::*;

    localparam logic REG_NORM_CONSTANT = 1'b0;

    logic [31:0] r_norm;
    logic        cfg_wr;
    logic        job_push, job_full, job_pop, job_empty;
    t_job        job_in, job_out;
    logic        res_push, res_full;
    t_out        res_in;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_NORM_CONSTANT) ? r_norm : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm <= NORM_RESET;
        end else if (cfg_wr && (paddr[2] == REG_NORM_CONSTANT)) begin
            r_norm <= pwdata;
        end
    end

    // front: square and accumulate
    assign full = job_full;

    gkd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .i_job_full (job_full),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    // queue of finished sums
    gkd_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    // back: exp and scaling
    gkd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_norm      (r_norm),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // output queue
    gkd_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

// File: verif/gaussian_kernel_density_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_kernel_density_core_tb: self-checking bench of the density core
// Streams component vectors into the item queue, predicts each vector's
// density with a bit-exact fixed-point model kept in the bench, and compares
// every popped result against it. norm_constant is reprogrammed over the APB
// port between phases, with random idling on both queue sides.
// ----------------------------------------------------------------------------
module gaussian_kernel_density_core_tb;

    import gkd_pkg::*;

    // Register map
    localparam logic [gkd_pkg::ADDR_W-1:0] NORM_ADDR   = 3'd0;
    localparam logic [gkd_pkg::ADDR_W-1:0] UNUSED_ADDR = 3'd4;

    // Fixed-point constants of the exp evaluation (Q0.32)
    localparam logic [63:0] HALF_LOG2E = 64'd3098164009;
    localparam logic [63:0] LN2_FRAC   = 64'd2977044472;
    localparam logic [63:0] ONE_FRAC   = 64'h1_0000_0000;
    localparam logic [63:0] SUM_CEIL   = 64'hFFFF_FFFF;
    localparam int          TAYLOR_LEN = 12;
    localparam logic [31:0] NORM_POR   = 32'd26145;

    localparam int SETTLE_CYCLES  = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       push    = 1'b0;
    t_in                        i_item  = '0;
    logic                       full;
    logic                       empty;
    logic                       pop     = 1'b0;
    t_out                       o_result;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [gkd_pkg::ADDR_W-1:0] paddr   = '0;
    logic [31:0]                pwdata  = '0;
    logic [31:0]                prdata;
    logic                       pready;

    gaussian_kernel_density_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Bench state
    t_in         pending_components[$];
    t_out        expected_densities[$];
    logic [63:0] sum_of_squares_q  = '0;
    logic        sum_ovf_q         = 1'b0;
    logic [63:0] norm_q16          = 64'(NORM_POR);
    int          queued_count      = 0;
    int          accepted_count    = 0;
    int          mismatch_count    = 0;
    int          feed_idle_pct     = 0;
    int          drain_idle_pct    = 0;
    bit          quiet_tail        = 1'b0;
    int          feed_gap          = 0;
    int          drain_gap         = 0;
    int          stall_cycles      = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Density of one finished vector: norm * exp(-0.5*sum), Q16.16
    function automatic t_out density_of(logic [63:0] sum, logic ovf, logic [63:0] norm);
        logic [63:0] t, n, f, u, term, p, prod, dens;
        longint      acc;
        int          k;
        int          sh;
        t_out        r;
        t    = sum * HALF_LOG2E;
        n    = t >> 56;
        f    = (t >> 24) & 64'hFFFF_FFFF;
        u    = (f * LN2_FRAC) >> 32;
        acc  = longint'(ONE_FRAC);
        term = ONE_FRAC;
        // exp(-u) by alternating Taylor series, truncated per term
        for (k = 1; k <= TAYLOR_LEN; k++) begin
            term = (term * u) >> 32;
            term = term / 64'(k);
            if (k % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        if (acc < 0)
            acc = 0;
        p = 64'(acc);
        if (p > ONE_FRAC)
            p = ONE_FRAC;
        prod = norm * p;
        sh   = 32 + int'(n);
        if (sh > 64)
            dens = '0;
        else if (sh == 64)
            dens = prod >> 63;
        else
            dens = (prod >> sh) + ((prod >> (sh - 1)) & 64'd1);
        r.saturated = ovf;
        if (dens > SUM_CEIL) begin
            dens        = SUM_CEIL;
            r.saturated = 1'b1;
        end
        r.density = dens[31:0];
        return r;
    endfunction

    // Add one accepted component; on last, queue the expected density
    task automatic accumulate_component(t_in item);
        logic [63:0] mag;
        mag = item.component[15] ? (64'h1_0000 - {48'd0, item.component})
                                 : {48'd0, item.component};
        sum_of_squares_q = sum_of_squares_q + mag * mag;
        if (sum_of_squares_q > SUM_CEIL) begin
            sum_of_squares_q = SUM_CEIL;
            sum_ovf_q        = 1'b1;
        end
        if (item.last) begin
            expected_densities.push_back(density_of(sum_of_squares_q, sum_ovf_q, norm_q16));
            sum_of_squares_q = '0;
            sum_ovf_q        = 1'b0;
        end
    endtask

    // Item driver: holds an item until taken, then fetches the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push     <= 1'b0;
            feed_gap = 0;
        end else if (!push || !full) begin
            if (push) begin
                accumulate_component(i_item);
                accepted_count++;
            end
            if (feed_gap > 0) begin
                feed_gap--;
                push <= 1'b0;
            end else if (pending_components.size() > 0) begin
                i_item <= pending_components.pop_front();
                push   <= 1'b1;
                if (!quiet_tail && $urandom_range(99) < feed_idle_pct)
                    feed_gap = $urandom_range(1, 9);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Result monitor: compares each popped transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            pop       <= 1'b0;
            drain_gap = 0;
        end else begin
            if (pop && !empty) begin
                if (expected_densities.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result density=%h saturated=%b",
                                 $realtime, o_result.density, o_result.saturated);
                end else begin
                    want = expected_densities.pop_front();
                    if (o_result.density !== want.density ||
                        o_result.saturated !== want.saturated) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: mismatch density exp=%h got=%h saturated exp=%b got=%b",
                                     $realtime, want.density, o_result.density,
                                     want.saturated, o_result.saturated);
                    end
                end
            end
            if (drain_gap > 0) begin
                drain_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if (!quiet_tail && $urandom_range(99) < drain_idle_pct)
                    drain_gap = $urandom_range(1, 9);
            end
        end
    end

    // Watchdog: no transaction on either queue for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_component(logic signed [15:0] comp, logic last);
        t_in item;
        item.component = comp;
        item.last      = last;
        pending_components.push_back(item);
        queued_count++;
    endtask

    // One vector of random length; magnitude bound picks the density range
    task automatic queue_random_vector(output int len);
        int mag_bits;
        int idx;
        logic [15:0] raw;
        if ($urandom_range(99) < 88)
            len = $urandom_range(1, 16);
        else
            len = $urandom_range(17, 40);
        mag_bits = ($urandom_range(9) < 7) ? $urandom_range(6, 13) : $urandom_range(14, 16);
        for (idx = 0; idx < len; idx++) begin
            if ($urandom_range(19) == 0)
                raw = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            else if (mag_bits == 16)
                raw = 16'($urandom_range(16'hFFFF));
            else begin
                raw = 16'($urandom_range((1 << mag_bits) - 1));
                if ($urandom_range(1))
                    raw = -raw;
            end
            queue_component(raw, idx == len - 1);
        end
    endtask

    task automatic queue_random_phase(int target);
        int added;
        int len;
        added = 0;
        while (added < target) begin
            queue_random_vector(len);
            added += len;
        end
    endtask

    // Wait for every queued item and every result, then for the pipeline to drain
    task automatic wait_idle();
        while (accepted_count != queued_count || expected_densities.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [gkd_pkg::ADDR_W-1:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == NORM_ADDR)
            norm_q16 = 64'(data);
    endtask

    // Stimulus sequence
    initial begin
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed vectors at the reset norm constant
        feed_idle_pct  = 20;
        drain_idle_pct = 20;
        queue_component(16'sd0, 1'b1);
        queue_component(16'sh7FFF, 1'b1);
        queue_component(16'sh8000, 1'b1);
        queue_component(16'sd1, 1'b1);
        queue_component(-16'sd1, 1'b1);
        queue_component(16'sd4096, 1'b1);
        queue_component(16'sh5A5A, 1'b1);
        queue_component(16'shA5A5, 1'b1);
        queue_component(16'sd4096, 1'b0);
        queue_component(-16'sd4096, 1'b0);
        queue_component(16'sd2048, 1'b1);
        // sum saturates after four full-scale squares; flag must clear after
        repeat (4) queue_component(16'sh8000, 1'b0);
        queue_component(16'sd0, 1'b1);
        queue_component(16'sd0, 1'b1);
        queue_component(16'sd300, 1'b0);
        queue_component(16'sd300, 1'b1);
        wait_idle();

        // Largest normalisation constant
        apb_write(NORM_ADDR, 32'hFFFF_FFFF);
        feed_idle_pct  = 10;
        drain_idle_pct = 40;
        queue_component(16'sd0, 1'b1);
        queue_random_phase(150);
        wait_idle();

        // Zero constant
        apb_write(NORM_ADDR, 32'd0);
        feed_idle_pct  = 40;
        drain_idle_pct = 5;
        queue_random_phase(120);
        wait_idle();

        // Write beyond the register map must leave the constant alone
        apb_write(UNUSED_ADDR, $urandom);
        feed_idle_pct  = 30;
        drain_idle_pct = 30;
        queue_random_phase(120);
        wait_idle();

        // Constant of 1.0
        apb_write(NORM_ADDR, 32'h0001_0000);
        feed_idle_pct  = 0;
        drain_idle_pct = 0;
        queue_random_phase(150);
        wait_idle();

        apb_write(NORM_ADDR, $urandom);
        feed_idle_pct  = 15;
        drain_idle_pct = 25;
        queue_random_phase(150);
        wait_idle();

        // Tail without idling
        apb_write(NORM_ADDR, $urandom);
        quiet_tail = 1'b1;
        queue_random_phase(150);
        wait_idle();

        mismatch_count += expected_densities.size();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
